>>> hdl/hpbp_pkg.sv
// Package for the HPACK header block parser: parser phases, event kinds,
// error codes, representation constants and the result record.
// No dependencies.
package hpbp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_IDX_CONT,
    PH_STR_HDR,
    PH_LEN_CONT,
    PH_STR_DATA
  } phase_t;

  typedef enum logic [1:0] {
    EV_DESC,
    EV_LEN,
    EV_BYTE,
    EV_ERR
  } event_kind_t;

  typedef enum logic [1:0] {
    INT_MORE,
    INT_DONE,
    INT_OVERFLOW
  } int_status_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  localparam logic [2:0] FT_INDEXED = 3'd0;
  localparam logic [2:0] FT_INCR    = 3'd1;
  localparam logic [2:0] FT_WITHOUT = 3'd3;
  localparam logic [2:0] FT_NEVER   = 3'd5;

  localparam logic [7:0] REP_INDEXED  = 8'h80;
  localparam logic [7:0] REP_INCR     = 8'h40;
  localparam logic [7:0] REP_HIGH_NIB = 8'hF0;
  localparam logic [7:0] REP_NEVER    = 8'h10;
  localparam logic [7:0] MASK_7       = 8'h7F;
  localparam logic [7:0] MASK_6       = 8'h3F;
  localparam logic [7:0] MASK_4       = 8'h0F;

  typedef struct packed {
    event_kind_t kind;
    logic [2:0]  field_type;
    logic [31:0] table_index;
    logic [31:0] string_length;
    logic        huffman_coded;
    logic        is_value;
    logic [7:0]  data_byte;
    logic        field_end;
    logic        block_end;
    logic [1:0]  error_code;
  } event_t;

endpackage

>>> hdl/hpbp_int_step.sv
// One continuation byte of an HPACK prefix integer: adds 7 bits at the
// current shift and flags overflow beyond INT_WIDTH bits.
// Depends on hpbp_pkg.
module hpbp_int_step
  import hpbp_pkg::*;
#(
  parameter int INT_WIDTH = 32
) (
  input  logic [7:0]                       in_byte,
  input  logic [INT_WIDTH-1:0]             acc,
  input  logic [$clog2(INT_WIDTH+7)-1:0]   shift,
  output logic [INT_WIDTH-1:0]             acc_next,
  output logic [$clog2(INT_WIDTH+7)-1:0]   shift_next,
  output int_status_t                      status
);

  localparam int SHIFT_W = $clog2(INT_WIDTH + 7);

  logic [INT_WIDTH+6:0] chunk_ext;
  logic [INT_WIDTH+6:0] shifted;
  logic [INT_WIDTH:0]   sum;

  assign chunk_ext = {{INT_WIDTH{1'b0}}, in_byte[6:0]};
  assign shifted   = chunk_ext << shift;
  assign sum       = {1'b0, acc} + {1'b0, shifted[INT_WIDTH-1:0]};

  always_comb begin
    acc_next   = acc;
    shift_next = shift;
    if (shift >= SHIFT_W'(INT_WIDTH)) begin
      status = INT_OVERFLOW;
    end else if ((|shifted[INT_WIDTH+6:INT_WIDTH]) || sum[INT_WIDTH]) begin
      status = INT_OVERFLOW;
    end else begin
      acc_next   = sum[INT_WIDTH-1:0];
      shift_next = shift + SHIFT_W'(7);
      status     = in_byte[7] ? INT_MORE : INT_DONE;
    end
  end

endmodule

>>> hdl/hpack_header_block_parser_unit.sv
// HPACK header block parser, top level: byte decoder state and result
// register. Depends on hpbp_pkg and hpbp_int_step.
//
// Usage: header block bytes enter on the s_ stream, one byte per beat,
// s_tlast on the final byte of a block. Each byte gives zero or one result
// beat on the m_ stream: a field descriptor, a string length, a raw string
// byte or an error. m_tlast marks a result caused by the final block byte.
// Latency: the result appears on m_ the cycle after its byte is accepted.
// Throughput: one byte per cycle while m_ is not stalled; the decode of a byte,
// including one prefix-integer continuation step, sits between the state
// registers and the single result register.
// Stall: while a result waits and m_tready is low, s_tready is low; when
// the result is taken in the same cycle a new byte is accepted.
// After an error all bytes up to and including the next s_tlast are
// dropped without results.
// Reset: rst (synchronous) returns the parser to await the first byte of
// a field and empties the result register.
module hpack_header_block_parser_unit
  import hpbp_pkg::*;
#(
  parameter int INT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tlast,  // block_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // [2:0] field_type, [34:3] table_index,
                                // [66:35] string_length, [67] huffman_coded,
                                // [68] is_value, [76:69] data_byte,
                                // [77] field_end, [79:78] error_code
  output logic [1:0]  m_tuser,  // [1:0] event_kind
  output logic        m_tlast   // block_end
);

  localparam int SHIFT_W = $clog2(INT_WIDTH + 7);

  phase_t               phase, phase_next;
  logic [INT_WIDTH-1:0] acc, acc_next;
  logic [SHIFT_W-1:0]   shift, shift_next;
  logic [2:0]           current_type, current_type_next;
  logic                 string_is_value, string_is_value_next;
  logic                 string_huffman, string_huffman_next;
  logic [31:0]          bytes_remaining, bytes_remaining_next;
  logic                 skip, skip_next;

  logic [INT_WIDTH-1:0] int_acc;
  logic [SHIFT_W-1:0]   int_shift;
  int_status_t          int_status;

  event_t               ev, result;
  logic                 ev_valid;
  logic                 accept;

  logic [7:0]           b;
  logic                 last;
  logic [7:0]           mask;
  logic [2:0]           ctype;
  logic                 idx_ready, len_ready;
  logic [1:0]           err;
  logic [INT_WIDTH-1:0] value;
  logic [INT_WIDTH+31:0] value_ext;
  logic [31:0]          value32;
  logic [31:0]          rem_dec;

  assign b      = s_tdata;
  assign last   = s_tlast;
  assign accept = s_tvalid && s_tready;

  hpbp_int_step #(
    .INT_WIDTH (INT_WIDTH)
  ) u_int_step (
    .in_byte    (b),
    .acc        (acc),
    .shift      (shift),
    .acc_next   (int_acc),
    .shift_next (int_shift),
    .status     (int_status)
  );

  assign value_ext = {32'b0, value};
  assign value32   = value_ext[31:0];
  assign rem_dec   = bytes_remaining - 32'd1;

  always_comb begin
    phase_next           = phase;
    acc_next             = acc;
    shift_next           = shift;
    current_type_next    = current_type;
    string_is_value_next = string_is_value;
    string_huffman_next  = string_huffman;
    bytes_remaining_next = bytes_remaining;
    skip_next            = skip;
    ev                   = '0;
    ev.block_end         = last;
    ev_valid             = 1'b0;
    err                  = ERR_NONE;
    idx_ready            = 1'b0;
    len_ready            = 1'b0;
    value                = '0;
    mask                 = MASK_7;
    ctype                = current_type;

    if (skip) begin
      if (last) begin
        skip_next  = 1'b0;
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if ((b & REP_INDEXED) != 8'h00) begin
            ctype = FT_INDEXED;
            mask  = MASK_7;
          end else if ((b & REP_INCR) != 8'h00) begin
            ctype = FT_INCR;
            mask  = MASK_6;
          end else if ((b & REP_HIGH_NIB) == 8'h00) begin
            ctype = FT_WITHOUT;
            mask  = MASK_4;
          end else if ((b & REP_NEVER) != 8'h00) begin
            ctype = FT_NEVER;
            mask  = MASK_4;
          end else begin
            err = ERR_UNKNOWN;
          end
          if (err == ERR_NONE) begin
            current_type_next = ctype;
            if ((b & mask) != mask) begin
              value     = INT_WIDTH'(b & mask);
              idx_ready = 1'b1;
            end else begin
              acc_next   = INT_WIDTH'(mask);
              shift_next = '0;
              phase_next = PH_IDX_CONT;
            end
          end
        end
        PH_IDX_CONT, PH_LEN_CONT: begin
          case (int_status)
            INT_OVERFLOW: err = ERR_OVERFLOW;
            INT_DONE: begin
              acc_next   = int_acc;
              shift_next = int_shift;
              value      = int_acc;
              if (phase == PH_IDX_CONT) begin
                idx_ready = 1'b1;
              end else begin
                len_ready = 1'b1;
              end
            end
            INT_MORE: begin
              acc_next   = int_acc;
              shift_next = int_shift;
            end
            default: err = ERR_OVERFLOW;
          endcase
        end
        PH_STR_HDR: begin
          string_huffman_next = b[7];
          if (b[6:0] != MASK_7[6:0]) begin
            value     = INT_WIDTH'(b[6:0]);
            len_ready = 1'b1;
          end else begin
            acc_next   = INT_WIDTH'(MASK_7);
            shift_next = '0;
            phase_next = PH_LEN_CONT;
          end
        end
        PH_STR_DATA: begin
          bytes_remaining_next = rem_dec;
          ev_valid         = 1'b1;
          ev.kind          = EV_BYTE;
          ev.field_type    = current_type;
          ev.huffman_coded = string_huffman;
          ev.is_value      = string_is_value;
          ev.data_byte     = b;
          if (rem_dec == 32'd0) begin
            if (string_is_value) begin
              ev.field_end = 1'b1;
              phase_next   = PH_IDLE;
            end else begin
              string_is_value_next = 1'b1;
              phase_next           = PH_STR_HDR;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      if (idx_ready) begin
        if (ctype != FT_INDEXED && value == '0) begin
          ctype = ctype + 3'd1;
        end
        current_type_next = ctype;
        ev_valid          = 1'b1;
        ev.kind           = EV_DESC;
        ev.field_type     = ctype;
        ev.table_index    = value32;
        if (ctype == FT_INDEXED) begin
          ev.field_end = 1'b1;
          phase_next   = PH_IDLE;
        end else begin
          string_is_value_next = (value != '0);
          phase_next           = PH_STR_HDR;
        end
      end

      if (len_ready) begin
        bytes_remaining_next = value32;
        ev_valid         = 1'b1;
        ev.kind          = EV_LEN;
        ev.field_type    = current_type;
        ev.string_length = value32;
        ev.huffman_coded = string_huffman_next;
        ev.is_value      = string_is_value;
        if (value32 == 32'd0) begin
          if (string_is_value) begin
            ev.field_end = 1'b1;
            phase_next   = PH_IDLE;
          end else begin
            string_is_value_next = 1'b1;
            phase_next           = PH_STR_HDR;
          end
        end else begin
          phase_next = PH_STR_DATA;
        end
      end

      if (err != ERR_NONE) begin
        ev            = '0;
        ev.kind       = EV_ERR;
        ev.block_end  = last;
        ev.error_code = err;
        ev_valid      = 1'b1;
        phase_next    = PH_IDLE;
        skip_next     = !last;
      end else if (last && phase_next != PH_IDLE) begin
        ev            = '0;
        ev.kind       = EV_ERR;
        ev.block_end  = 1'b1;
        ev.error_code = ERR_TRUNC;
        ev_valid      = 1'b1;
        phase_next    = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      acc             <= '0;
      shift           <= '0;
      current_type    <= '0;
      string_is_value <= 1'b0;
      string_huffman  <= 1'b0;
      bytes_remaining <= '0;
      skip            <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      acc             <= acc_next;
      shift           <= shift_next;
      current_type    <= current_type_next;
      string_is_value <= string_is_value_next;
      string_huffman  <= string_huffman_next;
      bytes_remaining <= bytes_remaining_next;
      skip            <= skip_next;
    end
  end

  // result register; refilled in the cycle the old beat is taken
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= ev_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev_valid) begin
      result <= ev;
    end
  end

  assign m_tuser = result.kind;
  assign m_tlast = result.block_end;
  assign m_tdata = {result.error_code, result.field_end, result.data_byte,
                    result.is_value, result.huffman_coded, result.string_length,
                    result.table_index, result.field_type};

`ifndef SYNTHESIS
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.kind == EV_ERR |-> !result.field_end && result.field_type == 3'd0)
    else $error("error beat carries field data");

  a_indexed_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.kind == EV_DESC && result.field_type == FT_INDEXED
    |-> result.field_end)
    else $error("indexed descriptor without field end");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> phase == PH_IDLE && !skip)
    else $error("parser not idle after block end");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    accept && skip |=> !m_tvalid)
    else $error("result produced while skipping");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result register not cleared by reset");
`endif

endmodule

>>> sim/tb.sv
// Testbench for hpack_header_block_parser_unit: random and directed HPACK header
// blocks stream in, and every result beat is checked field by field against an
// in-bench decoder. Depends on hpbp_pkg and the parser RTL.
module tb;
  import hpbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          INT_WIDTH       = 32;
  localparam logic [63:0] INT_MAX         = 64'hFFFF_FFFF;
  localparam int          STIM_BEATS      = 2000;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          DRAIN_LIMIT     = 5000;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam logic [7:0]  REP_WITHOUT     = 8'h00;
  localparam logic [7:0]  REP_SIZE_UPDATE = 8'h20;
  localparam logic [7:0]  HUFF_FLAG       = 8'h80;
  localparam logic [7:0]  CONT_FLAG       = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  hpack_header_block_parser_unit #(.INT_WIDTH(INT_WIDTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  beat_t  pending_beats[$];
  beat_t  block_beats[$];
  event_t expected_events[$];
  int     beats_sent = 0;
  int     total_beats = 1;
  int     mismatches = 0;
  int     cycle_count = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;

  // decoder state
  phase_t      parse_phase = PH_IDLE;
  logic [63:0] int_acc = '0;
  int          int_shift = 0;
  logic [2:0]  cur_type = '0;
  logic        str_is_value = 1'b0;
  logic        str_huff = 1'b0;
  logic [31:0] bytes_left = '0;
  logic        skipping = 1'b0;

  function automatic int_status_t prefix_int_step(input logic [7:0] b);
    logic [63:0] chunk;
    logic [63:0] sum;
    chunk = {57'd0, b[6:0]};
    if (int_shift >= INT_WIDTH) return INT_OVERFLOW;
    if (chunk != 0) begin
      if (int_shift + 7 > INT_WIDTH && (chunk >> (INT_WIDTH - int_shift)) != 0)
        return INT_OVERFLOW;
      sum = int_acc + (chunk << int_shift);
      if (sum > INT_MAX) return INT_OVERFLOW;
      int_acc = sum;
    end
    int_shift += 7;
    return b[7] ? INT_MORE : INT_DONE;
  endfunction

  // returns 1 when the finished string was the value, i.e. the field is done
  function automatic logic end_of_string();
    if (str_is_value) begin
      parse_phase = PH_IDLE;
      return 1'b1;
    end
    str_is_value = 1'b1;
    parse_phase = PH_STR_HDR;
    return 1'b0;
  endfunction

  function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                       output event_t ev);
    logic [1:0]  err;
    logic        idx_ready;
    logic        len_ready;
    logic        has;
    logic        fend;
    logic        isval;
    logic [63:0] value;
    logic [7:0]  mask;
    int_status_t st;
    ev = '0;
    err = ERR_NONE;
    idx_ready = 1'b0;
    len_ready = 1'b0;
    has = 1'b0;
    fend = 1'b0;
    value = '0;
    mask = '0;
    if (skipping) begin
      if (last) begin
        skipping = 1'b0;
        parse_phase = PH_IDLE;
      end
      return 1'b0;
    end
    case (parse_phase)
      PH_IDLE: begin
        if ((b & REP_INDEXED) != 0) begin
          cur_type = FT_INDEXED;
          mask = MASK_7;
        end else if ((b & REP_INCR) != 0) begin
          cur_type = FT_INCR;
          mask = MASK_6;
        end else if ((b & REP_HIGH_NIB) == 0) begin
          cur_type = FT_WITHOUT;
          mask = MASK_4;
        end else if ((b & REP_NEVER) != 0) begin
          cur_type = FT_NEVER;
          mask = MASK_4;
        end else begin
          err = ERR_UNKNOWN;
        end
        if (err == ERR_NONE) begin
          if ((b & mask) < mask) begin
            value = {56'd0, b & mask};
            idx_ready = 1'b1;
          end else begin
            int_acc = {56'd0, mask};
            int_shift = 0;
            parse_phase = PH_IDX_CONT;
          end
        end
      end
      PH_IDX_CONT: begin
        st = prefix_int_step(b);
        if (st == INT_OVERFLOW) err = ERR_OVERFLOW;
        else if (st == INT_DONE) begin
          value = int_acc;
          idx_ready = 1'b1;
        end
      end
      PH_STR_HDR: begin
        str_huff = b[7];
        if (b[6:0] < MASK_7[6:0]) begin
          value = {57'd0, b[6:0]};
          len_ready = 1'b1;
        end else begin
          int_acc = {56'd0, MASK_7};
          int_shift = 0;
          parse_phase = PH_LEN_CONT;
        end
      end
      PH_LEN_CONT: begin
        st = prefix_int_step(b);
        if (st == INT_OVERFLOW) err = ERR_OVERFLOW;
        else if (st == INT_DONE) begin
          value = int_acc;
          len_ready = 1'b1;
        end
      end
      PH_STR_DATA: begin
        isval = str_is_value;
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) fend = end_of_string();
        ev.kind = EV_BYTE;
        ev.field_type = cur_type;
        ev.huffman_coded = str_huff;
        ev.is_value = isval;
        ev.data_byte = b;
        ev.field_end = fend;
        ev.block_end = last;
        has = 1'b1;
      end
      default: parse_phase = PH_IDLE;
    endcase

    if (idx_ready) begin
      if (cur_type != FT_INDEXED && value == 0) cur_type = cur_type + 3'd1;
      if (cur_type == FT_INDEXED) begin
        fend = 1'b1;
        parse_phase = PH_IDLE;
      end else begin
        str_is_value = (value != 0);
        parse_phase = PH_STR_HDR;
      end
      ev = '0;
      ev.kind = EV_DESC;
      ev.field_type = cur_type;
      ev.table_index = value[31:0];
      ev.field_end = fend;
      ev.block_end = last;
      has = 1'b1;
    end
    if (len_ready) begin
      isval = str_is_value;
      bytes_left = value[31:0];
      if (bytes_left == 0) fend = end_of_string();
      else parse_phase = PH_STR_DATA;
      ev = '0;
      ev.kind = EV_LEN;
      ev.field_type = cur_type;
      ev.string_length = value[31:0];
      ev.huffman_coded = str_huff;
      ev.is_value = isval;
      ev.field_end = fend;
      ev.block_end = last;
      has = 1'b1;
    end

    if (err != ERR_NONE) begin
      ev = '0;
      ev.kind = EV_ERR;
      ev.block_end = last;
      ev.error_code = err;
      parse_phase = PH_IDLE;
      skipping = !last;
      return 1'b1;
    end
    if (last && parse_phase != PH_IDLE) begin
      ev = '0;
      ev.kind = EV_ERR;
      ev.block_end = 1'b1;
      ev.error_code = ERR_TRUNC;
      parse_phase = PH_IDLE;
      return 1'b1;
    end
    return has;
  endfunction

  // ---------------- stimulus building ----------------
  task automatic put_byte(input logic [7:0] v);
    block_beats.insert(block_beats.size(), beat_t'({v, 1'b0}));
  endtask

  task automatic put_cont(input logic [63:0] v);
    while (v >= 128) begin
      put_byte(CONT_FLAG | {1'b0, v[6:0]});
      v = v >> 7;
    end
    put_byte({1'b0, v[6:0]});
  endtask

  task automatic put_int(input int bits, input logic [7:0] pattern, input logic [63:0] v);
    logic [7:0] mask;
    mask = 8'((1 << bits) - 1);
    if (v < mask) put_byte(pattern | v[7:0]);
    else begin
      put_byte(pattern | mask);
      put_cont(v - mask);
    end
  endtask

  task automatic put_string(input logic [63:0] len);
    put_int(7, $urandom_range(0, 1) ? HUFF_FLAG : 8'h00, len);
    repeat (int'(len)) put_byte(8'($urandom));
  endtask

  task automatic close_block();
    if (block_beats.size() > 0) begin
      block_beats[block_beats.size() - 1].last = 1'b1;
      foreach (block_beats[i]) pending_beats.insert(pending_beats.size(), block_beats[i]);
      block_beats.delete();
    end
  endtask

  function automatic logic [63:0] pick_value(input logic [7:0] mask);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 64'($urandom_range(0, 2 * mask + 2));
      5, 6:          return 64'(mask) - 1 + 64'($urandom_range(0, 2));
      7:             return 64'(mask) + 64'($urandom_range(126, 130));
      8:             return 64'($urandom);
      default:       return INT_MAX - 64'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [63:0] pick_len();
    case ($urandom_range(0, 19))
      16, 17:  return 64'($urandom_range(7, 20));
      18:      return 64'($urandom_range(125, 129));
      19:      return 64'd0;
      default: return 64'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic put_field();
    logic [63:0] idx;
    logic [7:0]  pattern;
    int          bits;
    int          kind;
    kind = $urandom_range(0, 3);
    if (kind == 0) begin
      put_int(7, REP_INDEXED, pick_value(MASK_7));
      return;
    end
    case (kind)
      1: begin
        pattern = REP_INCR;
        bits = 6;
      end
      2: begin
        pattern = REP_WITHOUT;
        bits = 4;
      end
      default: begin
        pattern = REP_NEVER;
        bits = 4;
      end
    endcase
    idx = ($urandom_range(0, 2) == 0) ? 64'd0 : pick_value(bits == 6 ? MASK_6 : MASK_4);
    put_int(bits, pattern, idx);
    if (idx == 0) put_string(pick_len());
    put_string(pick_len());
  endtask

  // integer that cannot fit, in an index or a string length
  task automatic put_overflow();
    int v;
    if ($urandom_range(0, 1)) put_byte(REP_INDEXED | MASK_7);
    else begin
      put_int(6, REP_INCR, 64'($urandom_range(1, 62)));
      put_byte(($urandom_range(0, 1) ? HUFF_FLAG : 8'h00) | MASK_7);
    end
    case ($urandom_range(0, 2))
      0: begin
        repeat (4) put_byte(CONT_FLAG | MASK_7);
        v = $urandom_range(16, 127);
        put_byte(8'(v) | ($urandom_range(0, 1) ? CONT_FLAG : 8'h00));
      end
      1: begin
        repeat (5) put_byte(CONT_FLAG);
        put_byte(8'($urandom));
      end
      default: put_cont(INT_MAX + 1 - MASK_7 + 64'($urandom_range(0, 1000)));
    endcase
  endtask

  task automatic put_broken_block();
    int keep;
    repeat ($urandom_range(0, 2)) put_field();
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 3)) put_field();
        keep = $urandom_range(1, block_beats.size());
        while (block_beats.size() > keep) void'(block_beats.pop_back());
      end
      1: begin
        put_byte(REP_SIZE_UPDATE | 8'($urandom_range(0, 31)));
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
      end
      2: begin
        put_overflow();
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
      end
      default: begin
        put_int(6, REP_INCR, 64'($urandom_range(1, 62)));
        put_int(7, $urandom_range(0, 1) ? HUFF_FLAG : 8'h00,
                64'($urandom_range(200, 32'hFFFF_FFFF)));
        repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
      end
    endcase
    close_block();
  endtask

  // ---------------- idling ----------------
  function automatic int sender_idle_pct();
    case (beats_sent * 5 / total_beats)
      1: return 68;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (beats_sent * 5 / total_beats)
      2: return 68;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin : drive
    event_t ev;
    beat_t  nb;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        beats_sent <= beats_sent + 1;
        if (decode_byte(s_tdata, s_tlast, ev))
          expected_events.insert(expected_events.size(), ev);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nb = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nb.data;
          s_tlast <= nb.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_event();
    event_t want;
    event_t got;
    got.kind = event_kind_t'(m_tuser);
    got.field_type = m_tdata[2:0];
    got.table_index = m_tdata[34:3];
    got.string_length = m_tdata[66:35];
    got.huffman_coded = m_tdata[67];
    got.is_value = m_tdata[68];
    got.data_byte = m_tdata[76:69];
    got.field_end = m_tdata[77];
    got.block_end = m_tlast;
    got.error_code = m_tdata[79:78];
    if (expected_events.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected beat, expected none, actual tuser %0h tdata %h",
               $time, m_tuser, m_tdata);
      return;
    end
    want = expected_events.pop_front();
    compare_field("event_kind", 32'(want.kind), 32'(got.kind));
    compare_field("field_type", 32'(want.field_type), 32'(got.field_type));
    compare_field("table_index", want.table_index, got.table_index);
    compare_field("string_length", want.string_length, got.string_length);
    compare_field("huffman_coded", 32'(want.huffman_coded), 32'(got.huffman_coded));
    compare_field("is_value", 32'(want.is_value), 32'(got.is_value));
    compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
    compare_field("field_end", 32'(want.field_end), 32'(got.field_end));
    compare_field("block_end", 32'(want.block_end), 32'(got.block_end));
    compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
  endtask

  // one long hold-off early on, while the sender keeps pushing
  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_sent >= total_beats / 10) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_event();
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------- sequence ----------------
  initial begin
    int drain;
    // indexed field with index zero
    put_byte(REP_INDEXED);
    close_block();
    // largest index
    put_int(7, REP_INDEXED, INT_MAX);
    close_block();
    // incremental new name (empty Huffman name), never-indexed new name
    put_byte(REP_INCR);
    put_byte(HUFF_FLAG);
    put_byte(8'h01);
    put_byte(8'hFF);
    put_byte(REP_NEVER);
    put_byte(8'h01);
    put_byte(8'h00);
    put_byte(8'h00);
    close_block();
    // size update byte 0x3F has bit 4 set, so it decodes as never-indexed; block truncated
    put_byte(REP_SIZE_UPDATE | 8'h1F);
    put_byte(8'h80);
    put_byte(8'h81);
    close_block();
    // overflow on the final byte
    put_byte(REP_INDEXED | MASK_7);
    repeat (4) put_byte(CONT_FLAG | MASK_7);
    put_byte(8'h10);
    close_block();
    // block ends right after a literal descriptor
    put_byte(REP_INCR | 8'h01);
    close_block();
    // without indexing, index fills the 4-bit prefix
    put_int(4, REP_WITHOUT, 64'd15);
    put_byte(8'h00);
    close_block();

    while (pending_beats.size() < STIM_BEATS) begin
      case ($urandom_range(0, 99)) inside
        [0:79]: begin
          repeat ($urandom_range(1, 4)) put_field();
          close_block();
        end
        [80:94]: put_broken_block();
        default: begin
          repeat ($urandom_range(1, 10)) put_byte(8'($urandom));
          close_block();
        end
      endcase
    end
    total_beats = pending_beats.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() > 0 || s_tvalid) @(posedge clk);
    drain = 0;
    while (expected_events.size() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (expected_events.size() > 0) begin
      $display("%0t: %0d results missing, expected more beats, actual none", $time,
               expected_events.size());
      mismatches += expected_events.size();
    end
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> hpack_header_block_parser_unit.f
hdl/hpbp_pkg.sv
hdl/hpbp_int_step.sv
hdl/hpack_header_block_parser_unit.sv
sim/tb.sv
